[sv/nnrs_pkg.sv]
package nnrs_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int FRAC_BITS = 16;

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int IDX_W = 24;
	localparam int SF_W  = 29;
	localparam int SR_W  = 17;
	localparam int OFF_W = 12;
	localparam int CRD_W = 12;

	localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	localparam logic [2:0] REG_SCALE_FACTOR  = 3'd0;
	localparam logic [2:0] REG_SCALE_RATIO   = 3'd1;
	localparam logic [2:0] REG_X_OFFSET      = 3'd2;
	localparam logic [2:0] REG_Y_OFFSET      = 3'd3;
	localparam logic [2:0] REG_CLIENT_WIDTH  = 3'd4;
	localparam logic [2:0] REG_DISPLAY_WIDTH = 3'd5;

	localparam logic [SF_W-1:0]  SCALE_FACTOR_RST = SF_W'(65536);
	localparam logic [SR_W-1:0]  SCALE_RATIO_RST  = SR_W'(65537);
	localparam logic [DIM_W-1:0] WIDTH_RST        = DIM_W'(640);

	// One display pixel handed from the walker to the address unit.
	typedef struct packed {
		logic [DIM_W-1:0] wx;
		logic [DIM_W-1:0] wy;
		logic             last;
	} coord_t;

	typedef struct packed {
		logic [SR_W-1:0]  scale_ratio;
		logic [OFF_W-1:0] x_offset;
		logic [OFF_W-1:0] y_offset;
		logic [DIM_W-1:0] client_width;
		logic [DIM_W-1:0] display_width;
	} cfg_t;

endpackage

[sv/nnrs_if.sv]
interface nnrs_in_if;
	import nnrs_pkg::*;

	logic             valid;
	logic             ready;
	logic             func;
	logic [CRD_W-1:0] rect_x;
	logic [CRD_W-1:0] rect_y;
	logic [DIM_W-1:0] rect_w;
	logic [DIM_W-1:0] rect_h;

	modport source (output valid, func, rect_x, rect_y, rect_w, rect_h, input ready);
	modport sink (input valid, func, rect_x, rect_y, rect_w, rect_h, output ready);
	modport mon (input valid, ready, func, rect_x, rect_y, rect_w, rect_h);
endinterface

interface nnrs_out_if;
	import nnrs_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] dst_index;
	logic [IDX_W-1:0] src_index;
	logic             last;

	modport source (output valid, dst_index, src_index, last, input ready);
	modport sink (input valid, dst_index, src_index, last, output ready);
	modport mon (input valid, ready, dst_index, src_index, last);
endinterface

[sv/nnrs_front.sv]
module nnrs_front (
	input  logic                       clk,
	input  logic                       arst_n,
	nnrs_in_if.sink                    cmd,
	input  logic [nnrs_pkg::SF_W-1:0]  scale_factor,
	input  logic                       q_full,
	output logic                       q_push,
	output nnrs_pkg::coord_t           q_data
);
	import nnrs_pkg::*;

	localparam int PW = DIM_W + SF_W;

	localparam logic [2:0] LD_IDLE = 3'd0;
	localparam logic [2:0] LD_X    = 3'd1;
	localparam logic [2:0] LD_Y    = 3'd2;
	localparam logic [2:0] LD_W    = 3'd3;
	localparam logic [2:0] LD_H    = 3'd4;
	localparam logic [2:0] LD_FIN  = 3'd5;

	logic [2:0]       ld_state_q;
	logic [CRD_W-1:0] rx_q, ry_q;
	logic [DIM_W-1:0] rw_q, rh_q;
	logic [PW-1:0]    prod_q;
	logic [DIM_W-1:0] py_q;
	logic [DIM_W-1:0] start_col_q, end_col_q, end_row_q;
	logic [DIM_W-1:0] walk_x_q, walk_y_q;
	logic             busy_q;

	logic             accept;
	logic [DIM_W-1:0] ld_op;
	logic [DIM_W-1:0] dim_prod;
	logic [DIM_W-1:0] end_row_new;
	logic [DIM_W:0]   x_next, y_next;
	logic             row_done;

	function automatic logic [DIM_W-1:0] to_dim(input logic [PW-1:0] p);
		logic [PW-1:0] s;
		s = p >> FRAC_BITS;
		if (s > PW'(MAX_DIM)) begin
			return DIM_W'(MAX_DIM);
		end
		return DIM_W'(s);
	endfunction

	function automatic logic [DIM_W-1:0] sat_sum(input logic [DIM_W-1:0] a,
		input logic [DIM_W-1:0] b);
		logic [DIM_W:0] s;
		s = (DIM_W+1)'(a) + (DIM_W+1)'(b);
		if (s > (DIM_W+1)'(MAX_DIM)) begin
			return DIM_W'(MAX_DIM);
		end
		return DIM_W'(s);
	endfunction

	assign cmd.ready = (ld_state_q == LD_IDLE) && !q_full;
	assign accept    = cmd.valid && cmd.ready;

	always_comb begin
		case (ld_state_q)
			LD_X:    ld_op = DIM_W'(rx_q);
			LD_Y:    ld_op = DIM_W'(ry_q);
			LD_W:    ld_op = rw_q;
			LD_H:    ld_op = rh_q;
			default: ld_op = '0;
		endcase
	end

	assign dim_prod    = to_dim(prod_q);
	assign end_row_new = sat_sum(py_q, dim_prod);

	assign x_next   = (DIM_W+1)'(walk_x_q) + (DIM_W+1)'(1);
	assign y_next   = (DIM_W+1)'(walk_y_q) + (DIM_W+1)'(1);
	assign row_done = x_next >= (DIM_W+1)'(end_col_q);

	// A step taken while no rectangle is open is consumed and dropped.
	assign q_push    = accept && (cmd.func == FUNC_STEP) && busy_q;
	assign q_data.wx = walk_x_q;
	assign q_data.wy = walk_y_q;
	assign q_data.last = row_done && (y_next >= (DIM_W+1)'(end_row_q));

	always_ff @(posedge clk) begin
		if (accept && (cmd.func == FUNC_LOAD)) begin
			rx_q <= cmd.rect_x;
			ry_q <= cmd.rect_y;
			rw_q <= cmd.rect_w;
			rh_q <= cmd.rect_h;
		end
		prod_q <= PW'(ld_op) * PW'(scale_factor);
		if (ld_state_q == LD_W) begin
			py_q <= dim_prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_state_q  <= LD_IDLE;
			start_col_q <= '0;
			end_col_q   <= '0;
			end_row_q   <= '0;
			walk_x_q    <= '0;
			walk_y_q    <= '0;
			busy_q      <= 1'b0;
		end else begin
			case (ld_state_q)
				LD_IDLE: begin
					if (accept && (cmd.func == FUNC_LOAD)) begin
						ld_state_q <= LD_X;
					end else if (q_push) begin
						if (row_done) begin
							walk_x_q <= start_col_q;
							walk_y_q <= DIM_W'(y_next);
							if (y_next >= (DIM_W+1)'(end_row_q)) begin
								busy_q <= 1'b0;
							end
						end else begin
							walk_x_q <= DIM_W'(x_next);
						end
					end
				end
				LD_X: ld_state_q <= LD_Y;
				LD_Y: begin
					start_col_q <= dim_prod;
					ld_state_q  <= LD_W;
				end
				LD_W: ld_state_q <= LD_H;
				LD_H: begin
					end_col_q  <= sat_sum(start_col_q, dim_prod);
					ld_state_q <= LD_FIN;
				end
				LD_FIN: begin
					end_row_q  <= end_row_new;
					walk_x_q   <= start_col_q;
					walk_y_q   <= py_q;
					busy_q     <= (start_col_q < end_col_q) && (py_q < end_row_new);
					ld_state_q <= LD_IDLE;
				end
				default: ld_state_q <= LD_IDLE;
			endcase
		end
	end

endmodule

[sv/nnrs_queue.sv]
module nnrs_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  nnrs_pkg::coord_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output nnrs_pkg::coord_t pop_data
);
	import nnrs_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	coord_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	assign full     = count_q == CNT_W'(DEPTH);
	assign valid    = count_q != '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[sv/nnrs_back.sv]
module nnrs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  nnrs_pkg::coord_t q_data,
	output logic             q_pop,
	input  nnrs_pkg::cfg_t   cfg,
	nnrs_out_if.source       pix
);
	import nnrs_pkg::*;

	localparam int AW = DIM_W + 1;
	localparam int MW = AW + SR_W;

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_SX    = 2'd1;
	localparam logic [1:0] PH_SRC   = 2'd2;
	localparam logic [1:0] PH_DST   = 2'd3;

	logic [1:0]       phase_q;
	logic             pend_q;
	logic             out_valid_q;
	coord_t           cur_q;
	logic [MW-1:0]    prod_q;
	logic [AW-1:0]    sy_q, sx_q;
	logic [IDX_W-1:0] src_q;
	logic [IDX_W-1:0] dst_out_q, src_out_q;
	logic             last_out_q;

	logic             out_free;
	logic             retire;
	logic             start;
	logic [AW-1:0]    mul_a;
	logic [SR_W-1:0]  mul_b;

	function automatic logic [IDX_W-1:0] sat_idx(input logic [MW:0] v);
		if (v > (MW+1)'(IDX_MAX)) begin
			return IDX_MAX;
		end
		return IDX_W'(v);
	endfunction

	assign out_free = !out_valid_q || pix.ready;
	// prod_q holds the finished row product until the output register can take it.
	assign retire   = pend_q && out_free;
	assign start    = (phase_q == PH_START) && q_valid && (!pend_q || out_free);
	assign q_pop    = start;

	always_comb begin
		case (phase_q)
			PH_START: begin
				mul_a = AW'(q_data.wy);
				mul_b = cfg.scale_ratio;
			end
			PH_SX: begin
				mul_a = AW'(cur_q.wx);
				mul_b = cfg.scale_ratio;
			end
			PH_SRC: begin
				mul_a = sy_q;
				mul_b = SR_W'(cfg.client_width);
			end
			PH_DST: begin
				mul_a = AW'(cfg.y_offset) + AW'(cur_q.wy);
				mul_b = SR_W'(cfg.display_width);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (start || (phase_q != PH_START)) begin
			prod_q <= MW'(mul_a) * MW'(mul_b);
		end
		if (start) begin
			cur_q <= q_data;
		end
		if (phase_q == PH_SX) begin
			sy_q <= AW'(prod_q >> FRAC_BITS);
		end
		if (phase_q == PH_SRC) begin
			sx_q <= AW'(prod_q >> FRAC_BITS);
		end
		if (phase_q == PH_DST) begin
			src_q <= sat_idx((MW+1)'(prod_q) + (MW+1)'(sx_q));
		end
		if (retire) begin
			dst_out_q  <= sat_idx((MW+1)'(prod_q) + (MW+1)'(cur_q.wx)
				+ (MW+1)'(cfg.x_offset));
			src_out_q  <= src_q;
			last_out_q <= cur_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (phase_q)
				PH_START: begin
					if (start) begin
						phase_q <= PH_SX;
					end
				end
				PH_SX:  phase_q <= PH_SRC;
				PH_SRC: phase_q <= PH_DST;
				PH_DST: phase_q <= PH_START;
				default: phase_q <= PH_START;
			endcase
			if (phase_q == PH_DST) begin
				pend_q <= 1'b1;
			end else if (retire) begin
				pend_q <= 1'b0;
			end
			if (retire) begin
				out_valid_q <= 1'b1;
			end else if (pix.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign pix.valid     = out_valid_q;
	assign pix.dst_index = dst_out_q;
	assign pix.src_index = src_out_q;
	assign pix.last      = last_out_q;

endmodule

[sv/nearest_neighbor_rect_scaler.sv]
// Address generator for a letterboxed nearest-neighbour upscale. A load on cmd (func 0)
// scales the client rectangle into display space with scale_factor; the four products
// share one multiplier, so a load holds cmd off until it is done. Each step on cmd
// (func 1) while a rectangle is open yields one transfer on pix carrying the display
// index, the nearest client index and a last flag; steps while idle are dropped.
// Steps are taken into a QUEUE_DEPTH entry queue while not full, and the address unit
// behind it takes each pixel through its phases on one shared multiplier, starting no
// new pixel until the last is finished. Indices saturate at 2^24-1. Registers sit on
// APB byte addresses 4*i and must be written only while idle; the block does not check.
module nearest_neighbor_rect_scaler #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	nnrs_in_if.sink     cmd,
	nnrs_out_if.source  pix,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import nnrs_pkg::*;

	logic [SF_W-1:0] scale_factor_q;
	cfg_t            cfg_q;
	logic            wr_en;
	logic [2:0]      reg_idx;

	logic   q_push, q_full, q_pop, q_valid;
	coord_t q_in, q_out;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_factor_q      <= SCALE_FACTOR_RST;
			cfg_q.scale_ratio   <= SCALE_RATIO_RST;
			cfg_q.x_offset      <= '0;
			cfg_q.y_offset      <= '0;
			cfg_q.client_width  <= WIDTH_RST;
			cfg_q.display_width <= WIDTH_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SCALE_FACTOR:  scale_factor_q      <= pwdata[SF_W-1:0];
				REG_SCALE_RATIO:   cfg_q.scale_ratio   <= pwdata[SR_W-1:0];
				REG_X_OFFSET:      cfg_q.x_offset      <= pwdata[OFF_W-1:0];
				REG_Y_OFFSET:      cfg_q.y_offset      <= pwdata[OFF_W-1:0];
				REG_CLIENT_WIDTH:  cfg_q.client_width  <= pwdata[DIM_W-1:0];
				REG_DISPLAY_WIDTH: cfg_q.display_width <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SCALE_FACTOR:  prdata = 32'(scale_factor_q);
			REG_SCALE_RATIO:   prdata = 32'(cfg_q.scale_ratio);
			REG_X_OFFSET:      prdata = 32'(cfg_q.x_offset);
			REG_Y_OFFSET:      prdata = 32'(cfg_q.y_offset);
			REG_CLIENT_WIDTH:  prdata = 32'(cfg_q.client_width);
			REG_DISPLAY_WIDTH: prdata = 32'(cfg_q.display_width);
			default:           prdata = '0;
		endcase
	end

	nnrs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.scale_factor (scale_factor_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_in)
	);

	nnrs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_out)
	);

	nnrs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_out),
		.q_pop   (q_pop),
		.cfg     (cfg_q),
		.pix     (pix)
	);

endmodule

[sv/nnrs_checker.sv]
module nnrs_checker (
	input logic        clk,
	input logic        arst_n,
	nnrs_in_if.sink    cmd,
	nnrs_out_if.source pix
);
	import nnrs_pkg::*;

	// Steps taken minus transfers delivered; dropped steps only make it larger.
	logic [31:0] open_steps_q;
	logic        step_xfer, pix_xfer;

	assign step_xfer = cmd.valid && cmd.ready && (cmd.func == FUNC_STEP);
	assign pix_xfer  = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_steps_q <= '0;
		end else if (step_xfer && !pix_xfer) begin
			open_steps_q <= open_steps_q + 32'd1;
		end else if (pix_xfer && !step_xfer) begin
			open_steps_q <= open_steps_q - 32'd1;
		end
	end

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !pix.valid)
		else $error("result shown during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid && !pix.ready |=> pix.valid && $stable(pix.dst_index)
			&& $stable(pix.src_index) && $stable(pix.last))
		else $error("stalled result changed");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		pix.valid |-> open_steps_q != 32'd0)
		else $error("result without a step");

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready && (cmd.func == FUNC_LOAD) |=> !cmd.ready)
		else $error("item taken while a load is being scaled");

endmodule

bind nearest_neighbor_rect_scaler nnrs_checker u_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.cmd    (cmd),
	.pix    (pix)
);
